// ===== hdl/ogrm_pkg.sv =====
package ogrm_pkg;

  typedef enum logic [1:0] {
    OP_MARK  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_TILE  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_BOUNDS,
    ST_RD,
    ST_WR,
    ST_DONE
  } state_t;

  localparam int CELL_SHIFT = 5;
  localparam int TILE_GROUP_SHIFT = 2;
  localparam logic [7:0] TILE_WALL_A = 8'd1;
  localparam logic [7:0] TILE_WALL_B = 8'd2;
  localparam logic [7:0] WALL_MASK_RESET = 8'd1;

  typedef struct packed {
    logic load;
    logic init_wr;
    logic calc;
    logic rd;
    logic wr;
  } cmd_t;

  typedef struct packed {
    logic init_last;
    logic empty;
    logic last_cell;
  } status_t;

endpackage

// ===== hdl/occupancy_grid_rect_marker_core.sv =====
// occupancy grid of GRID_W x GRID_H flag bytes, one cell per 32x32 pixel area
// input: drive the in_ fields with start high; the item is taken at an edge
//   where start is high and busy is low
// ops: mark ORs flag_mask into every cell under the box, clear removes the
//   mask bits from all cells, tile sets wall_mask in a wall tile's cell,
//   read returns one cell
// result: out_valid strobes for one cycle with out_cell_flags (zero for all
//   but read); the receiver cannot stall, so nothing waits on it
// flow: an item passes a bounds step, then a read and a write state for each
//   covered cell (none for an empty box), then the done state with the strobe;
//   each cell is a read-modify-write on the single-port grid memory, which sets
//   the rate; the next item can be taken the cycle after the strobe
// config: cfg_data is written into wall_mask whenever cfg_valid is high;
//   cfg_ready is always high
// reset: wall_mask returns to 1 and the grid memory is swept to zero one
//   cell a cycle, with busy held high meanwhile
module occupancy_grid_rect_marker_core #(
  parameter int GRID_W = 32,
  parameter int GRID_H = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_op,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic [9:0]         in_half_width,
  input  logic [9:0]         in_height,
  input  logic [7:0]         in_flag_mask,
  input  logic [6:0]         in_tile_x,
  input  logic [6:0]         in_tile_y,
  input  logic [7:0]         in_tile_value,
  input  logic [4:0]         in_cell_x,
  input  logic [4:0]         in_cell_y,
  output logic               out_valid,
  output logic [7:0]         out_cell_flags,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);
  import ogrm_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  ogrm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  ogrm_dp #(
    .GRID_W (GRID_W),
    .GRID_H (GRID_H)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_valid & cfg_ready),
    .cfg_data       (cfg_data),
    .in_op          (in_op),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_half_width  (in_half_width),
    .in_height      (in_height),
    .in_flag_mask   (in_flag_mask),
    .in_tile_x      (in_tile_x),
    .in_tile_y      (in_tile_y),
    .in_tile_value  (in_tile_value),
    .in_cell_x      (in_cell_x),
    .in_cell_y      (in_cell_y),
    .out_cell_flags (out_cell_flags)
  );

endmodule

// ===== hdl/ogrm_ctrl.sv =====
module ogrm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  ogrm_pkg::status_t status,
  output ogrm_pkg::cmd_t   cmd,
  output logic             busy,
  output logic             out_valid
);
  import ogrm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (status.init_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_nxt = ST_BOUNDS;
      end
      ST_BOUNDS: begin
        state_nxt = status.empty ? ST_DONE : ST_RD;
      end
      ST_RD: begin
        state_nxt = ST_WR;
      end
      ST_WR: begin
        state_nxt = status.last_cell ? ST_DONE : ST_RD;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_INIT: begin
        cmd.init_wr = 1'b1;
      end
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_BOUNDS: begin
        cmd.calc = 1'b1;
      end
      ST_RD: begin
        cmd.rd = 1'b1;
      end
      ST_WR: begin
        cmd.wr = 1'b1;
      end
      ST_DONE: begin
        out_valid = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== hdl/ogrm_dp.sv =====
module ogrm_dp #(
  parameter int GRID_W = 32,
  parameter int GRID_H = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ogrm_pkg::cmd_t     cmd,
  output ogrm_pkg::status_t  status,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data,
  input  logic [1:0]         in_op,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic [9:0]         in_half_width,
  input  logic [9:0]         in_height,
  input  logic [7:0]         in_flag_mask,
  input  logic [6:0]         in_tile_x,
  input  logic [6:0]         in_tile_y,
  input  logic [7:0]         in_tile_value,
  input  logic [4:0]         in_cell_x,
  input  logic [4:0]         in_cell_y,
  output logic [7:0]         out_cell_flags
);
  import ogrm_pkg::*;

  localparam int NCELLS = GRID_W * GRID_H;
  localparam int XW = (GRID_W > 1) ? $clog2(GRID_W) : 1;
  localparam int YW = (GRID_H > 1) ? $clog2(GRID_H) : 1;
  localparam int AW = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int BW = 18 - CELL_SHIFT;

  // latched item
  op_t                op_r;
  logic signed [15:0] pos_x_r, pos_y_r;
  logic [9:0]         half_width_r, height_r;
  logic [7:0]         flag_mask_r;
  logic [6:0]         tile_x_r, tile_y_r;
  logic [7:0]         tile_value_r;
  logic [4:0]         cell_x_r, cell_y_r;

  logic [7:0]    wall_mask_r;
  logic [7:0]    mask_r;
  logic [XW-1:0] xs_r, xe_r, cx_r;
  logic [YW-1:0] ye_r, cy_r;
  logic [AW-1:0] init_cnt_r;
  logic [7:0]    rdata_r;
  logic [7:0]    res_r;
  logic [7:0]    mem [NCELLS];

  // box bounds in cells
  logic signed [17:0]   x_lo, x_hi, y_lo, y_hi;
  logic signed [BW-1:0] bx_lo, bx_hi, by_lo, by_hi;
  logic signed [BW-1:0] cx_lo, cx_hi, cy_lo, cy_hi;
  logic                 box_empty;
  logic [4:0]           tcx, tcy;
  logic                 tile_ok, read_ok;
  logic                 calc_empty;
  logic [AW-1:0]        addr;
  logic [7:0]           wdata;

  assign x_lo = 18'(pos_x_r) - $signed({8'd0, half_width_r});
  assign x_hi = 18'(pos_x_r) + $signed({8'd0, half_width_r});
  assign y_lo = 18'(pos_y_r) - $signed({8'd0, height_r});
  assign y_hi = 18'(pos_y_r);

  assign bx_lo = x_lo[17:CELL_SHIFT];
  assign bx_hi = x_hi[17:CELL_SHIFT];
  assign by_lo = y_lo[17:CELL_SHIFT];
  assign by_hi = y_hi[17:CELL_SHIFT];

  assign cx_lo = (bx_lo < 0) ? '0 : bx_lo;
  assign cy_lo = (by_lo < 0) ? '0 : by_lo;
  assign cx_hi = (bx_hi > $signed(BW'(GRID_W - 1))) ? $signed(BW'(GRID_W - 1)) : bx_hi;
  assign cy_hi = (by_hi > $signed(BW'(GRID_H - 1))) ? $signed(BW'(GRID_H - 1)) : by_hi;
  assign box_empty = (cx_lo > cx_hi) || (cy_lo > cy_hi);

  assign tcx = tile_x_r[6:TILE_GROUP_SHIFT];
  assign tcy = tile_y_r[6:TILE_GROUP_SHIFT];
  assign tile_ok = ((tile_value_r == TILE_WALL_A) || (tile_value_r == TILE_WALL_B))
                   && (32'(tcx) < GRID_W) && (32'(tcy) < GRID_H);
  assign read_ok = (32'(cell_x_r) < GRID_W) && (32'(cell_y_r) < GRID_H);

  always_comb begin
    case (op_r)
      OP_MARK:  calc_empty = box_empty;
      OP_CLEAR: calc_empty = 1'b0;
      OP_TILE:  calc_empty = !tile_ok;
      OP_READ:  calc_empty = !read_ok;
      default:  calc_empty = 1'b1;
    endcase
  end

  assign status.empty     = calc_empty;
  assign status.last_cell = (cx_r == xe_r) && (cy_r == ye_r);
  assign status.init_last = (init_cnt_r == AW'(NCELLS - 1));

  assign addr = cmd.init_wr ? init_cnt_r
                            : AW'(32'(cy_r) * GRID_W + 32'(cx_r));

  always_comb begin
    if (op_r == OP_CLEAR) begin
      wdata = rdata_r & ~mask_r;
    end else begin
      wdata = rdata_r | mask_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_wr) begin
      mem[addr] <= '0;
    end else if (cmd.wr && (op_r != OP_READ)) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd) rdata_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_cnt_r  <= '0;
      wall_mask_r <= WALL_MASK_RESET;
    end else begin
      if (cmd.init_wr) init_cnt_r <= init_cnt_r + AW'(1);
      if (cfg_we) wall_mask_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r         <= op_t'(in_op);
      pos_x_r      <= in_pos_x;
      pos_y_r      <= in_pos_y;
      half_width_r <= in_half_width;
      height_r     <= in_height;
      flag_mask_r  <= in_flag_mask;
      tile_x_r     <= in_tile_x;
      tile_y_r     <= in_tile_y;
      tile_value_r <= in_tile_value;
      cell_x_r     <= in_cell_x;
      cell_y_r     <= in_cell_y;
      res_r        <= '0;
    end
    if (cmd.calc) begin
      mask_r <= (op_r == OP_TILE) ? wall_mask_r : flag_mask_r;
      case (op_r)
        OP_MARK: begin
          xs_r <= XW'(cx_lo);
          xe_r <= XW'(cx_hi);
          ye_r <= YW'(cy_hi);
          cx_r <= XW'(cx_lo);
          cy_r <= YW'(cy_lo);
        end
        OP_CLEAR: begin
          xs_r <= '0;
          xe_r <= XW'(GRID_W - 1);
          ye_r <= YW'(GRID_H - 1);
          cx_r <= '0;
          cy_r <= '0;
        end
        OP_TILE: begin
          xs_r   <= XW'(tcx);
          xe_r   <= XW'(tcx);
          ye_r   <= YW'(tcy);
          cx_r   <= XW'(tcx);
          cy_r   <= YW'(tcy);
        end
        default: begin
          xs_r <= XW'(cell_x_r);
          xe_r <= XW'(cell_x_r);
          ye_r <= YW'(cell_y_r);
          cx_r <= XW'(cell_x_r);
          cy_r <= YW'(cell_y_r);
        end
      endcase
    end
    if (cmd.wr) begin
      if (op_r == OP_READ) res_r <= rdata_r;
      // raster walk over the cell range, row by row
      if (cx_r == xe_r) begin
        cx_r <= xs_r;
        cy_r <= cy_r + YW'(1);
      end else begin
        cx_r <= cx_r + XW'(1);
      end
    end
  end

  assign out_cell_flags = res_r;

endmodule
